// ===== hdl/pdm_pkg.sv =====
// ----------------------------------------------------------------------------
// PWM meter package
// Shared widths, constants and state types for the PWM period and duty meter.
// ----------------------------------------------------------------------------
package pdm_pkg;

  // Widths of the result fields and of the configuration register.
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned DUTY_W  = 7;
  localparam int unsigned CLOCK_W = 24;

  // Reset value of the tick rate register, in Hz.
  localparam logic [CLOCK_W-1:0] CLOCK_RESET = 24'd16000000;

  // Scale factor that turns the high/period ratio into percent.
  localparam int unsigned DUTY_SCALE = 100;

  // Capture sequence: which edge the meter is waiting for.
  typedef enum logic [1:0] {
    PH_WAIT_RISE  = 2'd0,
    PH_WAIT_FALL  = 2'd1,
    PH_WAIT_RISE2 = 2'd2
  } pdm_phase_t;

  // Sequencer of the shared divider.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_SETUP = 3'd1,
    ST_DUTY  = 3'd2,
    ST_FREQ  = 3'd3,
    ST_EMIT  = 3'd4
  } pdm_state_t;

endpackage

// ===== hdl/pdm_channels.sv =====
// ----------------------------------------------------------------------------
// PWM meter channels
// Valid/ready interfaces for the sample, result and configuration channels.
// ----------------------------------------------------------------------------

// One signal sample per beat.
interface pdm_sample_if;
  logic valid;
  logic ready;
  logic signal_level;

  modport source (output valid, output signal_level, input ready);
  modport sink   (input valid, input signal_level, output ready);
endinterface

// One finished measurement per beat.
interface pdm_result_if;
  import pdm_pkg::*;

  logic               valid;
  logic               ready;
  logic               in_range;
  logic [TICK_W-1:0]  high_ticks;
  logic [TICK_W-1:0]  period_ticks;
  logic [DUTY_W-1:0]  duty_percent;
  logic [CLOCK_W-1:0] frequency_hz;

  modport source (output valid, output in_range, output high_ticks, output period_ticks,
                  output duty_percent, output frequency_hz, input ready);
  modport sink   (input valid, input in_range, input high_ticks, input period_ticks,
                  input duty_percent, input frequency_hz, output ready);
endinterface

// Write channel of the tick rate register.
interface pdm_cfg_if;
  import pdm_pkg::*;

  logic               valid;
  logic               ready;
  logic [CLOCK_W-1:0] ref_clock_hz;

  modport source (output valid, output ref_clock_hz, input ready);
  modport sink   (input valid, input ref_clock_hz, output ready);
endinterface

// ===== hdl/pwm_period_duty_meter.sv =====
// ----------------------------------------------------------------------------
// PWM period and duty meter
// Stamps a rising, a falling and a second rising edge of a sampled signal and
// reports high time, period, duty cycle in percent and frequency.
// ----------------------------------------------------------------------------
//
// Usage:
//   sample carries one level of the measured signal per beat; each accepted
//   beat is one tick of the wrapping COUNTER_BITS-bit capture counter.
//   result carries one measurement per completed rising-falling-rising set.
//   cfg writes the tick rate in Hz used for the frequency; it is always ready
//   and the user must see that it is written only while no measurement is
//   in progress; the block itself does not enforce this.
// Throughput:
//   While waiting for edges a sample is accepted every cycle. The beat that
//   completes a measurement starts the shared restoring divider, which makes
//   one quotient bit per cycle. A setup step, the duty cycle quotient, the
//   frequency quotient (dividend width DIV_W = max(COUNTER_BITS + 7, 24),
//   24 at the default) and the load of the output register all pass before
//   the next sample is taken. An out-of-range measurement skips the divider.
// Reset: the tick counter, edge history and capture sequence clear, the tick
//   rate returns to 16 MHz and the output register empties.
// Stall: the result waits in the output register; samples keep flowing until
//   a further measurement finishes while the previous one is still unread.
module pwm_period_duty_meter #(
  parameter int unsigned COUNTER_BITS = 16
) (
  input logic                clk,
  input logic                rst,
  pdm_sample_if.sink         sample,
  pdm_cfg_if.sink            cfg,
  pdm_result_if.source       result
);
  import pdm_pkg::*;

  localparam int unsigned CB    = COUNTER_BITS;
  localparam int unsigned DIV_W = (CB + DUTY_W > CLOCK_W) ? CB + DUTY_W : CLOCK_W;
  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  // Control state.
  pdm_state_t         state;
  pdm_state_t         state_next;
  pdm_phase_t         phase;
  logic [CB-1:0]      tick_count;
  logic               prev_level;
  logic [CB-1:0]      rise_stamp;
  logic [CB-1:0]      fall_stamp;
  logic [CLOCK_W-1:0] ref_clock_hz;
  logic               out_valid;
  logic [CNT_W-1:0]   div_count;

  // Measurement and divider datapath.
  logic               ok_r;
  logic [CB-1:0]      high_r;
  logic [CB-1:0]      period_r;
  logic [DIV_W-1:0]   div_num;
  logic [CB-1:0]      div_rem;
  logic [DUTY_W-1:0]  duty_q;
  logic [CLOCK_W-1:0] freq_q;

  // Output register.
  logic               out_in_range;
  logic [TICK_W-1:0]  out_high;
  logic [TICK_W-1:0]  out_period;
  logic [DUTY_W-1:0]  out_duty;
  logic [CLOCK_W-1:0] out_freq;

  // Sequencer outputs and helpers.
  logic               sample_fire;
  logic               rising;
  logic               falling;
  logic               complete;
  logic               slot_free;
  logic               div_last;
  logic               sample_ready;
  logic               emit_load;

  // Divider step.
  logic [CB:0]        rem_shift;
  logic [CB-1:0]      rem_sub;
  logic               fits;
  logic [CB-1:0]      rem_step;
  logic [DIV_W-1:0]   num_step;

  // Edge detection on the accepted sample.
  assign sample_fire = sample.valid && sample_ready;
  assign rising      = sample.signal_level && !prev_level;
  assign falling     = !sample.signal_level && prev_level;
  assign complete    = sample_fire && rising && (phase == PH_WAIT_RISE2);
  assign slot_free   = !out_valid || result.ready;
  assign div_last    = (div_count == CNT_W'(1));

  // One restoring division step: shift in a dividend bit, subtract if it fits.
  // When it fits the difference is below the divisor, so its low bits suffice.
  assign rem_shift = {div_rem, div_num[DIV_W-1]};
  assign rem_sub   = rem_shift[CB-1:0] - period_r;
  assign fits      = (rem_shift >= {1'b0, period_r});
  assign rem_step  = fits ? rem_sub : rem_shift[CB-1:0];
  assign num_step  = {div_num[DIV_W-2:0], fits};

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (complete) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        state_next = ok_r ? ST_DUTY : ST_EMIT;
      end
      ST_DUTY: begin
        if (div_last) state_next = ST_FREQ;
      end
      ST_FREQ: begin
        if (div_last) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    sample_ready = 1'b0;
    emit_load    = 1'b0;
    case (state)
      ST_IDLE: sample_ready = 1'b1;
      ST_EMIT: emit_load    = slot_free;
      default: begin
        sample_ready = 1'b0;
        emit_load    = 1'b0;
      end
    endcase
  end

  assign sample.ready = sample_ready;
  assign cfg.ready    = 1'b1;

  // Control registers: sequencer, capture sequence, tick counter, register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      phase        <= PH_WAIT_RISE;
      tick_count   <= '0;
      prev_level   <= 1'b0;
      rise_stamp   <= '0;
      fall_stamp   <= '0;
      ref_clock_hz <= CLOCK_RESET;
      out_valid    <= 1'b0;
      div_count    <= '0;
    end else begin
      state <= state_next;

      if (cfg.valid) ref_clock_hz <= cfg.ref_clock_hz;

      if (sample_fire) begin
        prev_level <= sample.signal_level;
        tick_count <= tick_count + CB'(1);
        case (phase)
          PH_WAIT_FALL: begin
            if (falling) begin
              fall_stamp <= tick_count;
              phase      <= PH_WAIT_RISE2;
            end
          end
          PH_WAIT_RISE2: begin
            if (rising) phase <= PH_WAIT_RISE;
          end
          default: begin
            if (rising) begin
              rise_stamp <= tick_count;
              phase      <= PH_WAIT_FALL;
            end
          end
        endcase
      end

      // Step counter of the divider, reloaded for each quotient.
      case (state)
        ST_SETUP: div_count <= CNT_W'(DIV_W);
        ST_DUTY:  div_count <= div_last ? CNT_W'(DIV_W) : div_count - CNT_W'(1);
        ST_FREQ:  div_count <= div_count - CNT_W'(1);
        default:  div_count <= div_count;
      endcase

      // Output register empties on a taken beat and refills from the sequencer.
      if (emit_load) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
    end
  end

  // Datapath: capture results, shared divider and output register.
  always_ff @(posedge clk) begin
    if (complete) begin
      high_r   <= fall_stamp - rise_stamp;
      period_r <= tick_count - rise_stamp;
      ok_r     <= (rise_stamp < fall_stamp) && (fall_stamp < tick_count);
    end

    case (state)
      ST_SETUP: begin
        div_num <= DIV_W'(high_r) * DIV_W'(DUTY_SCALE);
        div_rem <= '0;
        duty_q  <= '0;
        freq_q  <= '0;
      end
      ST_DUTY: begin
        if (div_last) begin
          duty_q  <= num_step[DUTY_W-1:0];
          div_num <= DIV_W'(ref_clock_hz);
          div_rem <= '0;
        end else begin
          div_num <= num_step;
          div_rem <= rem_step;
        end
      end
      ST_FREQ: begin
        div_num <= num_step;
        div_rem <= rem_step;
        if (div_last) freq_q <= num_step[CLOCK_W-1:0];
      end
      default: begin
        div_num <= div_num;
        div_rem <= div_rem;
      end
    endcase

    if (emit_load) begin
      out_in_range <= ok_r;
      out_high     <= TICK_W'(high_r);
      out_period   <= TICK_W'(period_r);
      out_duty     <= duty_q;
      out_freq     <= freq_q;
    end
  end

  assign result.valid        = out_valid;
  assign result.in_range     = out_in_range;
  assign result.high_ticks   = out_high;
  assign result.period_ticks = out_period;
  assign result.duty_percent = out_duty;
  assign result.frequency_hz = out_freq;

`ifndef SYNTH
  // A completed edge set starts the divider sequence.
  a_complete_starts: assert property (@(posedge clk) disable iff (rst)
    complete |=> (state == ST_SETUP))
    else $error("completed measurement did not start the divider");

  // Loading the output register always presents a beat next cycle.
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    emit_load |=> out_valid)
    else $error("loaded result not presented");

  // An out-of-range result carries no duty cycle and no frequency.
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_in_range) |-> (out_duty == '0 && out_freq == '0))
    else $error("out-of-range result with nonzero quotient");

  // The duty cycle never exceeds one hundred percent.
  a_duty_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_duty <= DUTY_W'(DUTY_SCALE)))
    else $error("duty cycle above one hundred percent");
`endif

endmodule
